[design/sst_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted set table package
// Request and response payloads, cell control and neighbor link types, and
// the operation and status codes shared by the table and its cells.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_DELETE = 2'd1;
	localparam logic [1:0] REQ_LOOKUP = 2'd2;

	localparam logic STAT_DONE = 1'b0;
	localparam logic STAT_FULL = 1'b1;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [4:0] position;
		logic [4:0] count;
		logic       status;
	} rsp_t;

	typedef struct packed {
		logic               cmp_en;
		logic               ins_en;
		logic               del_en;
		logic signed [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] entry;
		logic               occ;
		logic               lt;
	} link_t;

endpackage

[design/sst_cell.sv]
// ----------------------------------------------------------------------------
// Sorted set table cell
// Holds one entry with its occupied flag. Compares the entry against the
// request value, then keeps it, takes the new value, or takes a neighbor's
// entry when the row shifts up on insert or down on delete.
// ----------------------------------------------------------------------------
module sst_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  sst_pkg::cmd_t  cmd,
	input  sst_pkg::link_t left,
	input  sst_pkg::link_t right,
	output sst_pkg::link_t link,
	output logic          eq
);
	import sst_pkg::*;

	logic signed [31:0] entry_q;
	logic               occ_q;
	logic               lt_q;
	logic               eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			lt_q  <= 1'b0;
			eq_q  <= 1'b0;
		end else if (cmd.cmp_en) begin
			lt_q <= occ_q && (entry_q < cmd.value);
			eq_q <= occ_q && (entry_q == cmd.value);
		end else if (cmd.ins_en && !lt_q) begin
			occ_q <= left.occ;
		end else if (cmd.del_en && !lt_q) begin
			occ_q <= right.occ;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_en && !lt_q) begin
			entry_q <= left.lt ? cmd.value : left.entry;
		end else if (cmd.del_en && !lt_q) begin
			entry_q <= right.entry;
		end
	end

	assign link = '{entry: entry_q, occ: occ_q, lt: lt_q};
	assign eq   = eq_q;

endmodule

[design/sorted_set_table.sv]
// ----------------------------------------------------------------------------
// Sorted set table
// Keeps up to CAPACITY distinct signed values in ascending order in a row of
// cells. Each request inserts, deletes or looks up one value.
// ----------------------------------------------------------------------------
//  channel  direction  payload  handshake
//  req      in         req_t    req_valid / req_ready
//  rsp      out        rsp_t    rsp_valid / rsp_ready
//
// A request is accepted, then compared in every cell, then the row shifts
// and the response register loads. The next request is accepted while
// a response still waits. A stalled response holds the update cycle, so the
// row changes only when the response register can take the result.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_set_table #(
	parameter int CAPACITY = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_ready,
	input  sst_pkg::req_t req,
	output logic         rsp_valid,
	input  logic         rsp_ready,
	output sst_pkg::rsp_t rsp
);
	import sst_pkg::*;

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]          state_q;
	req_t                req_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;
	logic [PW-1:0]       fill_q;
	logic [PW-1:0]       fill_next;
	logic [PW-1:0]       pos;
	logic [CAPACITY-1:0] lt_vec;
	logic [CAPACITY-1:0] eq_vec;
	link_t               links [CAPACITY];
	cmd_t                cmd;
	logic                upd_fire;
	logic                found;
	logic                full;
	logic                ins_go;
	logic                del_go;
	logic                status;

	function automatic logic [PW-1:0] therm_count(input logic [CAPACITY-1:0] t);
		logic [PW-1:0] p;
		logic [PW:0]   cand;
		logic [IW-1:0] idx;
		p = '0;
		for (int b = PW - 1; b >= 0; b--) begin
			cand = {1'b0, p} | ((PW + 1)'(1) << b);
			idx  = IW'(cand - (PW + 1)'(1));
			if (cand <= (PW + 1)'(CAPACITY)) begin
				if (t[idx]) begin
					p = cand[PW-1:0];
				end
			end
		end
		return p;
	endfunction

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			link_t left_l;
			link_t right_l;
			if (gi == 0) begin : g_first
				assign left_l = '{entry: '0, occ: 1'b1, lt: 1'b1};
			end else begin : g_mid_l
				assign left_l = links[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_l = '{entry: '0, occ: 1'b0, lt: 1'b0};
			end else begin : g_mid_r
				assign right_l = links[gi+1];
			end
			sst_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.cmd    (cmd),
				.left   (left_l),
				.right  (right_l),
				.link   (links[gi]),
				.eq     (eq_vec[gi])
			);
			assign lt_vec[gi] = links[gi].lt;
		end
	endgenerate

	assign req_ready = (state_q == ST_IDLE);
	assign upd_fire  = (state_q == ST_UPD) && (!rsp_valid_q || rsp_ready);
	assign found     = |eq_vec;
	assign pos       = therm_count(lt_vec);
	assign full      = (fill_q == PW'(CAPACITY));
	assign ins_go    = upd_fire && (req_q.req_type == REQ_INSERT) && !full && !found;
	assign del_go    = upd_fire && (req_q.req_type == REQ_DELETE) && found;
	assign status    = ((req_q.req_type == REQ_INSERT) && full) ? STAT_FULL : STAT_DONE;

	always_comb begin
		fill_next = fill_q;
		if (ins_go) begin
			fill_next = fill_q + PW'(1);
		end else if (del_go) begin
			fill_next = fill_q - PW'(1);
		end
	end

	assign cmd = '{cmp_en: (state_q == ST_CMP), ins_en: ins_go, del_en: del_go,
		value: req_q.value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			fill_q <= fill_next;
			if (upd_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (upd_fire) begin
			rsp_q <= '{found: found, position: 5'(pos), count: 5'(fill_next),
				status: status};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[design/sst_checker.sv]
// ----------------------------------------------------------------------------
// Sorted set table checker
// Port-level checks on the table's responses and request handshake.
// ----------------------------------------------------------------------------
module sst_checker #(
	parameter int CAPACITY = 16
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input sst_pkg::rsp_t rsp
);
	import sst_pkg::*;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (int'(rsp.count) <= CAPACITY))
		else $error("count exceeds capacity");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.status == STAT_FULL)) |-> (int'(rsp.count) == CAPACITY))
		else $error("full status with a table that is not full");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.position <= rsp.count))
		else $error("position beyond stored count");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while another is in progress");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled response changed");

endmodule

bind sorted_set_table sst_checker #(.CAPACITY(CAPACITY)) u_sst_checker (.*);
